### sv/vdc_pkg.sv
// Shared types and constants for the vertex descriptor cache.
// No dependencies; imported by every module of the block except vdc_ram.
`default_nettype none

package vdc_pkg;

    localparam int INDEX_BITS  = 16;
    localparam int ENTRIES     = 1 << INDEX_BITS;
    localparam int TAG_W       = 32 - INDEX_BITS;
    localparam int TAG_ENTRY_W = TAG_W + 1;
    localparam int DESC_W      = 64;

    localparam int BYPASS_BIT  = 31;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int OUT_DEPTH   = 2;
    localparam int OPTR_W      = $clog2(OUT_DEPTH);
    localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 98;

    // output tdata bit positions
    localparam int OUT_START_LSB = 0;
    localparam int OUT_SIZE_LSB  = 32;
    localparam int OUT_ADDR_LSB  = 64;
    localparam int OUT_END_BIT   = 96;
    localparam int OUT_DUMMY_BIT = 97;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic STATE_VALID = 1'b0;
    localparam logic STATE_MISS  = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOOKUP,
        KIND_BYPASS,
        KIND_UPDATE
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] vertex;
        logic [31:0] new_start;
        logic [31:0] new_size;
        logic        last;
    } t_item;

    typedef struct packed {
        logic [31:0] desc_start;
        logic [31:0] desc_size;
        logic        desc_state;
        logic [31:0] mem_addr;
        logic        mem_end;
        logic        mem_dummy;
        logic        out_last;
    } t_result;

endpackage

`default_nettype wire

### sv/vertex_descriptor_cache.sv
// Top level of the vertex descriptor cache: front end, back end and beat packing.
// Depends on vdc_pkg, vdc_front, vdc_back (and vdc_ram through vdc_back).
//
// Direct-mapped cache of vertex descriptors, 2^INDEX_BITS entries (65536 as built),
// indexed by the low INDEX_BITS of the vertex id. After reset a clearing sweep
// writes every entry, one per cycle; s_axis_tready stays low until it ends.
// After that one beat (lookup or update) is taken per cycle unless m_axis stalls,
// set by the single write port and single read port of the tag and descriptor RAMs.
// A lookup result passes the RAM read registers and the result queue to m_axis; updates
// produce no beat. A stalled m_axis backs up through the result and input queues.
`default_nettype none

module vertex_descriptor_cache
    import vdc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // vertex, new_start, new_size
    input  wire logic [0:0]             s_axis_tuser,  // cmd
    input  wire logic                   s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,  // desc_start, desc_size, mem_addr,
                                                       // mem_end, mem_dummy, zero pad
    output logic      [0:0]             m_axis_tuser,  // desc_state
    output logic                        m_axis_tlast
);

    t_item   item;
    logic    item_valid;
    logic    item_take;
    logic    busy;
    t_result res;

    vdc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_tdata (s_axis_tdata),
        .i_cmd   (s_axis_tuser[0]),
        .i_last  (s_axis_tlast),
        .i_busy  (busy),
        .o_item  (item),
        .o_valid (item_valid),
        .i_take  (item_take)
    );

    vdc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .i_valid     (item_valid),
        .o_take      (item_take),
        .o_busy      (busy),
        .o_res       (res),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {OUT_PAD_W'(0), res.mem_dummy, res.mem_end, res.mem_addr,
                           res.desc_size, res.desc_start};
    assign m_axis_tuser = res.desc_state;
    assign m_axis_tlast = res.out_last;

endmodule

`default_nettype wire

### sv/vdc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module vdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### sv/vdc_front.sv
// Front end: accepts input beats, classifies them, and queues them for the back end.
// Depends on vdc_pkg.
`default_nettype none

module vdc_front
    import vdc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [IN_TDATA_W-1:0] i_tdata,
    input  wire logic                  i_cmd,
    input  wire logic                  i_last,
    input  wire logic                  i_busy,
    output t_item                      o_item,
    output logic                       o_valid,
    input  wire logic                  i_take
);

    t_item             r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    t_item             n_item;
    logic              push;
    logic              pop;

    always_comb begin
        n_item.vertex    = i_tdata[31:0];
        n_item.new_start = i_tdata[63:32];
        n_item.new_size  = i_tdata[95:64];
        n_item.last      = i_last;
        if (i_cmd == CMD_UPDATE) begin
            n_item.kind = KIND_UPDATE;
        end else if (i_tdata[BYPASS_BIT]) begin
            n_item.kind = KIND_BYPASS;
        end else begin
            n_item.kind = KIND_LOOKUP;
        end
    end

    assign o_ready = !i_busy && (r_count < QCNT_W'(QUEUE_DEPTH));
    assign push    = i_valid && o_ready;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_take;
    assign o_item  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_item;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

### sv/vdc_back.sv
// Back end: clearing sweep, tag and descriptor RAMs, hit check and result queue.
// Depends on vdc_pkg and vdc_ram.
`default_nettype none

module vdc_back
    import vdc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_item      i_item,
    input  wire logic  i_valid,
    output logic       o_take,
    output logic       o_busy,
    output t_result    o_res,
    output logic       o_res_valid,
    input  wire logic  i_res_ready
);

    logic                  r_clr_busy;
    logic [INDEX_BITS-1:0] r_clr_addr;

    logic                  r_s1_valid;
    t_kind                 r_s1_kind;
    logic [31:0]           r_s1_vertex;
    logic                  r_s1_last;

    t_result               r_of [OUT_DEPTH];
    logic [OPTR_W-1:0]     r_of_wr;
    logic [OPTR_W-1:0]     r_of_rd;
    logic [OCNT_W-1:0]     r_of_count;

    logic                  pop;
    logic [OCNT_W:0]       used;
    logic [OCNT_W:0]       limit;
    logic                  room;
    logic                  is_update;

    logic                  tag_we;
    logic [INDEX_BITS-1:0] waddr;
    logic [TAG_ENTRY_W-1:0] tag_wdata;
    logic [DESC_W-1:0]     desc_wdata;
    logic                  rd_en;
    logic [TAG_ENTRY_W-1:0] tag_rdata;
    logic [DESC_W-1:0]     desc_rdata;

    logic                  hit;
    t_result               res;

    assign pop       = o_res_valid && i_res_ready;
    assign used      = {1'b0, r_of_count} + (OCNT_W + 1)'(r_s1_valid);
    assign limit     = (OCNT_W + 1)'(OUT_DEPTH) + (OCNT_W + 1)'(pop);
    assign room      = used < limit;
    assign is_update = (i_item.kind == KIND_UPDATE);

    assign o_busy = r_clr_busy;
    assign o_take = i_valid && !r_clr_busy && (is_update || room);
    assign rd_en  = o_take && !is_update;

    assign tag_we     = r_clr_busy || (o_take && is_update);
    assign waddr      = r_clr_busy ? r_clr_addr : i_item.vertex[INDEX_BITS-1:0];
    assign tag_wdata  = r_clr_busy ? '0 : {1'b1, i_item.vertex[31:INDEX_BITS]};
    assign desc_wdata = r_clr_busy ? '0 : {i_item.new_size, i_item.new_start};

    vdc_ram #(
        .WIDTH (TAG_ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (waddr),
        .i_wdata (tag_wdata),
        .i_re    (rd_en),
        .i_raddr (i_item.vertex[INDEX_BITS-1:0]),
        .o_rdata (tag_rdata)
    );

    vdc_ram #(
        .WIDTH (DESC_W),
        .DEPTH (ENTRIES)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (waddr),
        .i_wdata (desc_wdata),
        .i_re    (rd_en),
        .i_raddr (i_item.vertex[INDEX_BITS-1:0]),
        .o_rdata (desc_rdata)
    );

    assign hit = tag_rdata[TAG_W] && (tag_rdata[TAG_W-1:0] == r_s1_vertex[31:INDEX_BITS]);

    always_comb begin
        res.desc_start = r_s1_vertex;
        res.desc_size  = desc_rdata[63:32];
        res.desc_state = STATE_MISS;
        res.mem_addr   = r_s1_vertex;
        res.mem_end    = r_s1_last;
        res.out_last   = r_s1_last;
        case (r_s1_kind)
            KIND_BYPASS: begin
                res.desc_size  = '0;
                res.desc_state = STATE_VALID;
            end
            KIND_LOOKUP: begin
                if (hit) begin
                    res.desc_start = desc_rdata[31:0];
                    res.desc_state = STATE_VALID;
                end
            end
            default: begin
                res.desc_state = STATE_MISS;
            end
        endcase
        res.mem_dummy = (res.desc_state == STATE_VALID);
    end

    assign o_res       = r_of[r_of_rd];
    assign o_res_valid = (r_of_count != '0);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_kind   <= i_item.kind;
            r_s1_vertex <= i_item.vertex;
            r_s1_last   <= i_item.last;
        end
        if (r_s1_valid) begin
            r_of[r_of_wr] <= res;
        end
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s1_valid <= 1'b0;
            r_of_wr    <= '0;
            r_of_rd    <= '0;
            r_of_count <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_s1_valid <= rd_en;
            if (r_s1_valid) begin
                r_of_wr <= r_of_wr + 1'b1;
            end
            if (pop) begin
                r_of_rd <= r_of_rd + 1'b1;
            end
            r_of_count <= r_of_count + OCNT_W'(r_s1_valid) - OCNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

### sv/vdc_checker.sv
// Port-level assertions for vertex_descriptor_cache, attached by bind.
// Depends on vdc_pkg.
`default_nettype none

module vdc_checker
    import vdc_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [0:0]             m_axis_tuser,
    input wire logic                   m_axis_tlast
);

    // clearing sweep holds off input right after reset
    a_clear_blocks_input: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready during clearing sweep");

    a_no_beat_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat right after reset");

    a_dummy_vs_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_DUMMY_BIT] != m_axis_tuser[0]))
        else $error("mem_dummy does not match desc_state");

    a_miss_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser[0] == STATE_MISS)) |->
        (m_axis_tdata[OUT_START_LSB +: 32] == m_axis_tdata[OUT_ADDR_LSB +: 32]))
        else $error("miss beat start differs from address");

    a_end_vs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_END_BIT] == m_axis_tlast))
        else $error("mem_end differs from tlast");

endmodule

bind vertex_descriptor_cache vdc_checker u_vdc_checker (.*);

`default_nettype wire
